// ===== src/mau_pkg.sv =====
package mau_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ELEMS  = 16;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned ACC_W  = 66;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_EXEC   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        FN_MUL    = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_ADD_S  = 3'd3,
        FN_SUB_S  = 3'd4,
        FN_MUL_S  = 3'd5,
        FN_DIV_S  = 3'd6,
        FN_TRANSP = 3'd7
    } t_fn;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ACC,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > ACC_W'(MAX_VAL)) begin
            r = MAX_VAL;
        end else if (v < ACC_W'(MIN_VAL)) begin
            r = MIN_VAL;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/mau_ram.sv =====
module mau_ram (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [mau_pkg::IDX_W-1:0]            i_waddr,
    input  logic signed [mau_pkg::DATA_W-1:0]    i_wdata,
    input  logic [mau_pkg::IDX_W-1:0]            i_raddr,
    output logic signed [mau_pkg::DATA_W-1:0]    o_rdata
);

    logic signed [mau_pkg::DATA_W-1:0] r_mem [mau_pkg::ELEMS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/mau_div.sv =====
module mau_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [mau_pkg::DATA_W-1:0] i_dividend,
    input  logic signed [mau_pkg::DATA_W-1:0] i_divisor,
    output logic                              o_done,
    output logic signed [mau_pkg::DATA_W-1:0] o_quotient
);

    localparam int unsigned W = mau_pkg::DATA_W;

    logic         r_busy, n_busy;
    logic [4:0]   r_cnt, n_cnt;
    logic [W:0]   r_rem, n_rem;
    logic [W-1:0] r_q, n_q;
    logic [W-1:0] r_d, n_d;
    logic         r_neg, n_neg;
    logic         r_done, n_done;
    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;

    assign rem_sh  = {r_rem[W-1:0], r_q[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
            n_d    = i_divisor[W-1] ? W'(-i_divisor) : W'(i_divisor);
            n_neg  = i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            // restoring step, one quotient bit per cycle
            if (!rem_sub[W]) begin
                n_rem = rem_sub;
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_neg <= n_neg;
    end

    assign o_done = r_done;

    always_comb begin
        if (r_neg) begin
            o_quotient = -$signed(r_q);
        end else if (r_q[W-1]) begin
            o_quotient = mau_pkg::MAX_VAL;
        end else begin
            o_quotient = $signed(r_q);
        end
    end

endmodule

// ===== src/matrix4_arithmetic_unit_core.sv =====
// 4x4 fixed-point matrix unit, matrices A and B held in small on-chip rams.
// input channel: i_in_valid / o_in_stall with op, element index and value,
// function select and integer scalar. a load beat writes one element of A or
// B. an execute beat runs the selected function over all
// sixteen elements, stores the results, then writes them back into A while
// emitting sixteen beats on o_out_valid / i_out_stall, in row-major order,
// o_out_last on the final one and o_div_error on all of a divide by zero.
// one shared 32x32 multiplier, separate adders and an iterative divider do the work;
// the input stalls for the whole execute.
// execute steps per element: product reads, multiplies and accumulates for
// each of four terms, scalar multiply reads, multiplies and saturates, divide
// runs the 32-step divider, other functions read and compute. then the
// write-back/emit phase reads and emits each element in turn.
// when the receiver stalls, the pending beat holds and the write-back waits.
// reset (synchronous, active low) clears both matrices by an epoch-free
// method: valid bits per element make untouched entries read as zero.
module matrix4_arithmetic_unit_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_op,
    input  logic [3:0]                        i_element_index,
    input  logic signed [31:0]                i_element_value,
    input  logic [2:0]                        i_function_select,
    input  logic signed [31:0]                i_scalar_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [3:0]                        o_out_index,
    output logic signed [31:0]                o_out_value,
    output logic                              o_out_last,
    output logic                              o_div_error
);

    localparam int unsigned W  = mau_pkg::DATA_W;
    localparam int unsigned AW = mau_pkg::ACC_W;
    localparam int unsigned IW = mau_pkg::IDX_W;

    mau_pkg::t_state r_state, n_state;
    mau_pkg::t_fn    r_fn, n_fn;
    logic signed [W-1:0]    r_s, n_s;
    logic                   r_err, n_err;
    logic [IW-1:0]          r_i, n_i;
    logic [1:0]             r_e, n_e;
    logic signed [AW-1:0]   r_acc, n_acc;
    logic signed [2*W-1:0]  r_prod, n_prod;
    logic [IW-1:0]          r_j, n_j;
    logic [mau_pkg::ELEMS-1:0] r_va, n_va, r_vb, n_vb;

    logic                   r_ovalid, n_ovalid;
    logic [IW-1:0]          r_oidx, n_oidx;
    logic signed [W-1:0]    r_oval, n_oval;
    logic                   r_olast, n_olast;
    logic                   r_oerr, n_oerr;

    logic                   a_we, b_we, r_we;
    logic [IW-1:0]          a_waddr, b_waddr, a_raddr, b_raddr;
    logic signed [W-1:0]    a_wdata, b_wdata, r_wdata;
    logic signed [W-1:0]    a_rd, b_rd, r_rd, a_q, b_q;
    logic [IW-1:0]          r_ra_q, r_rb_q;

    logic                   div_start, div_done;
    logic signed [W-1:0]    div_q;
    logic signed [W-1:0]    mul_b;
    logic signed [2*W-1:0]  mult;
    logic signed [AW-1:0]   acc_sum;
    logic                   advance;

    mau_ram u_ram_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rd)
    );
    mau_ram u_ram_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rd)
    );
    mau_ram u_ram_r (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(r_i), .i_wdata(r_wdata),
        .i_raddr(r_j), .o_rdata(r_rd)
    );

    mau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(a_q), .i_divisor(r_s), .o_done(div_done), .o_quotient(div_q)
    );

    // entries never written since reset read as zero
    assign a_q = r_va[r_ra_q] ? a_rd : '0;
    assign b_q = r_vb[r_rb_q] ? b_rd : '0;

    always_comb begin
        priority if (r_fn == mau_pkg::FN_MUL) begin
            a_raddr = {r_i[3:2], r_e};
            b_raddr = {r_e, r_i[1:0]};
        end else if (r_fn == mau_pkg::FN_TRANSP) begin
            a_raddr = {r_i[1:0], r_i[3:2]};
            b_raddr = r_i;
        end else begin
            a_raddr = r_i;
            b_raddr = r_i;
        end
    end

    assign mul_b   = (r_fn == mau_pkg::FN_MUL) ? b_q : r_s;
    assign mult    = a_q * mul_b;
    assign acc_sum = r_acc + AW'(r_prod);

    always_comb begin
        n_state  = r_state;
        n_fn     = r_fn;
        n_s      = r_s;
        n_err    = r_err;
        n_i      = r_i;
        n_e      = r_e;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_j      = r_j;
        n_va     = r_va;
        n_vb     = r_vb;
        n_ovalid = r_ovalid & i_out_stall;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        n_olast  = r_olast;
        n_oerr   = r_oerr;
        a_we     = 1'b0;
        a_waddr  = i_element_index;
        a_wdata  = i_element_value;
        b_we     = 1'b0;
        b_waddr  = i_element_index;
        b_wdata  = i_element_value;
        r_we     = 1'b0;
        r_wdata  = a_q;
        div_start = 1'b0;
        advance  = 1'b0;

        unique case (r_state)
            mau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (mau_pkg::t_op'(i_op))
                        mau_pkg::OP_LOAD_A: begin
                            a_we = 1'b1;
                            n_va[i_element_index] = 1'b1;
                        end
                        mau_pkg::OP_LOAD_B: begin
                            b_we = 1'b1;
                            n_vb[i_element_index] = 1'b1;
                        end
                        mau_pkg::OP_EXEC: begin
                            n_fn    = mau_pkg::t_fn'(i_function_select);
                            n_s     = i_scalar_value;
                            n_err   = (i_function_select == mau_pkg::FN_DIV_S) &&
                                      (i_scalar_value == '0);
                            n_i     = '0;
                            n_e     = '0;
                            n_acc   = '0;
                            n_state = mau_pkg::ST_READ;
                        end
                        mau_pkg::OP_NONE: begin
                        end
                    endcase
                end
            end
            mau_pkg::ST_READ: begin
                n_state = mau_pkg::ST_EXEC;
            end
            mau_pkg::ST_EXEC: begin
                unique case (r_fn)
                    mau_pkg::FN_MUL, mau_pkg::FN_MUL_S: begin
                        n_prod  = mult;
                        n_state = mau_pkg::ST_ACC;
                    end
                    mau_pkg::FN_ADD: begin
                        r_wdata = mau_pkg::sat_acc(AW'(a_q) + AW'(b_q));
                        advance = 1'b1;
                    end
                    mau_pkg::FN_SUB: begin
                        r_wdata = mau_pkg::sat_acc(AW'(a_q) - AW'(b_q));
                        advance = 1'b1;
                    end
                    mau_pkg::FN_ADD_S: begin
                        r_wdata = mau_pkg::sat_acc(AW'(a_q) + (AW'(r_s) <<< FRAC_BITS));
                        advance = 1'b1;
                    end
                    mau_pkg::FN_SUB_S: begin
                        r_wdata = mau_pkg::sat_acc(AW'(a_q) - (AW'(r_s) <<< FRAC_BITS));
                        advance = 1'b1;
                    end
                    mau_pkg::FN_DIV_S: begin
                        if (r_err) begin
                            advance = 1'b1;
                        end else begin
                            div_start = 1'b1;
                            n_state   = mau_pkg::ST_DIV;
                        end
                    end
                    mau_pkg::FN_TRANSP: begin
                        advance = 1'b1;
                    end
                endcase
            end
            mau_pkg::ST_ACC: begin
                if (r_fn == mau_pkg::FN_MUL_S) begin
                    r_wdata = mau_pkg::sat_acc(AW'(r_prod));
                    advance = 1'b1;
                end else if (r_e != 2'd3) begin
                    n_acc   = acc_sum;
                    n_e     = r_e + 2'd1;
                    n_state = mau_pkg::ST_READ;
                end else begin
                    r_wdata = mau_pkg::sat_acc(acc_sum >>> FRAC_BITS);
                    advance = 1'b1;
                end
            end
            mau_pkg::ST_DIV: begin
                if (div_done) begin
                    r_wdata = div_q;
                    advance = 1'b1;
                end
            end
            mau_pkg::ST_EMIT_RD: begin
                n_state = mau_pkg::ST_EMIT_LD;
            end
            mau_pkg::ST_EMIT_LD: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_j;
                    n_oval   = r_rd;
                    n_olast  = (r_j == IW'(mau_pkg::ELEMS - 1));
                    n_oerr   = r_err;
                    a_we     = 1'b1;
                    a_waddr  = r_j;
                    a_wdata  = r_rd;
                    n_va[r_j] = 1'b1;
                    if (r_j == IW'(mau_pkg::ELEMS - 1)) begin
                        n_state = mau_pkg::ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = mau_pkg::ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = mau_pkg::ST_IDLE;
            end
        endcase

        if (advance) begin
            r_we  = 1'b1;
            n_e   = '0;
            n_acc = '0;
            if (r_i == IW'(mau_pkg::ELEMS - 1)) begin
                n_j     = '0;
                n_state = mau_pkg::ST_EMIT_RD;
            end else begin
                n_i     = r_i + 1'b1;
                n_state = mau_pkg::ST_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mau_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_va     <= '0;
            r_vb     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_va     <= n_va;
            r_vb     <= n_vb;
        end
        r_fn    <= n_fn;
        r_s     <= n_s;
        r_err   <= n_err;
        r_i     <= n_i;
        r_e     <= n_e;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_j     <= n_j;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
        r_ra_q  <= a_raddr;
        r_rb_q  <= b_raddr;
    end

    assign o_in_stall  = (r_state != mau_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_out_last  = r_olast;
    assign o_div_error = r_oerr;

endmodule

// ===== verif/mau_checker.sv =====
module mau_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic [2:0]         i_function_select,
    input  logic signed [31:0] i_scalar_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [3:0]         i_out_index,
    input  logic signed [31:0] i_out_value,
    input  logic               i_out_last,
    input  logic               i_div_error,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               last;
        logic               div_err;
    } t_elem;

    logic signed [31:0] mat_a [16];
    logic signed [31:0] mat_b [16];
    t_elem              elem_q [$];
    int                 errors;

    assign o_errors  = errors;
    assign o_pending = elem_q.size();

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // updates mat_a and queues the sixteen output beats
    task automatic run_function(input mau_pkg::t_fn fn, input logic signed [31:0] s);
        logic signed [31:0]  res [16];
        logic signed [127:0] acc;
        logic signed [127:0] sw;
        logic                err;
        t_elem               e;
        err = 1'b0;
        sw = s;
        for (int i = 0; i < 16; i++) begin
            case (fn)
                mau_pkg::FN_MUL: begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += 128'(mat_a[(i/4)*4+k]) * 128'(mat_b[k*4+i%4]);
                    res[i] = clamp32(acc >>> FRAC);
                end
                mau_pkg::FN_ADD:   res[i] = clamp32(128'(mat_a[i]) + 128'(mat_b[i]));
                mau_pkg::FN_SUB:   res[i] = clamp32(128'(mat_a[i]) - 128'(mat_b[i]));
                mau_pkg::FN_ADD_S: res[i] = clamp32(128'(mat_a[i]) + (sw <<< FRAC));
                mau_pkg::FN_SUB_S: res[i] = clamp32(128'(mat_a[i]) - (sw <<< FRAC));
                mau_pkg::FN_MUL_S: res[i] = clamp32(128'(mat_a[i]) * sw);
                mau_pkg::FN_DIV_S: begin
                    if (s == 0) begin
                        err = 1'b1;
                        res[i] = mat_a[i];
                    end else begin
                        res[i] = clamp32(128'(mat_a[i]) / sw);
                    end
                end
                default:  res[i] = mat_a[(i%4)*4+i/4];
            endcase
        end
        for (int i = 0; i < 16; i++) begin
            mat_a[i] = res[i];
            e.index = 4'(i);
            e.value = res[i];
            e.last = (i == 15);
            e.div_err = err;
            elem_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_elem exp_e;
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            elem_q.delete();
            errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (elem_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected out beat idx=%0d val=%h",
                            i_out_index, i_out_value);
                end else begin
                    exp_e = elem_q.pop_front();
                    if (exp_e != {i_out_index, i_out_value, i_out_last, i_div_error}) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp idx=%0d val=%h last=%b err=%b",
                                      " got idx=%0d val=%h last=%b err=%b"},
                                exp_e.index, exp_e.value, exp_e.last, exp_e.div_err,
                                i_out_index, i_out_value, i_out_last, i_div_error);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (mau_pkg::t_op'(i_op))
                    mau_pkg::OP_LOAD_A: mat_a[i_element_index] = i_element_value;
                    mau_pkg::OP_LOAD_B: mat_b[i_element_index] = i_element_value;
                    mau_pkg::OP_EXEC:
                        run_function(mau_pkg::t_fn'(i_function_select), i_scalar_value);
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int STALL_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [2:0]         function_select;
    logic signed [31:0] scalar_value;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
    logic               div_error;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 quiet_cycles;

    matrix4_arithmetic_unit_core u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_op(op), .i_element_index(element_index), .i_element_value(element_value),
        .i_function_select(function_select), .i_scalar_value(scalar_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_index(out_index),
        .o_out_value(out_value), .o_out_last(out_last), .o_div_error(div_error)
    );

    mau_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_element_index(element_index), .i_element_value(element_value),
        .i_function_select(function_select), .i_scalar_value(scalar_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_index(out_index),
        .i_out_value(out_value), .i_out_last(out_last), .i_div_error(div_error),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'(($urandom_range(8) - 4)) << 16;
            3:       return 32'($urandom_range(2) - 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_scalar();
        case ($urandom_range(7))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            2:       return $urandom();
            3:       return 32'h80000000;
            default: return 32'($urandom_range(10)) - 32'd5;
        endcase
    endfunction

    // one beat, held until accepted; valid stays up until the next beat or idle
    task automatic send_beat(input mau_pkg::t_op o, input logic [3:0] idx,
                             input logic [31:0] val, input mau_pkg::t_fn fn,
                             input logic [31:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        element_index <= idx;
        element_value <= val;
        function_select <= fn;
        scalar_value <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_pair();
        for (int i = 0; i < 16; i++) begin
            send_beat(mau_pkg::OP_LOAD_A, 4'(i), pick_value(), mau_pkg::FN_MUL, $urandom());
            send_beat(mau_pkg::OP_LOAD_B, 4'(i), pick_value(), mau_pkg::FN_ADD, $urandom());
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = mau_pkg::OP_LOAD_A;
        element_index = '0;
        element_value = '0;
        function_select = mau_pkg::FN_MUL;
        scalar_value = '0;
        send_idle_pct = 29;
        recv_idle_pct = 81;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every function on extreme data, division by zero, op three
        send_beat(mau_pkg::OP_LOAD_A, 4'd0, 32'h7fffffff, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_LOAD_A, 4'd15, 32'h80000000, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_LOAD_A, 4'd5, 32'hfffe8000, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_LOAD_B, 4'd0, 32'h7fffffff, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_LOAD_B, 4'd15, 32'h80000000, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_LOAD_B, 4'd10, 32'h00018000, mau_pkg::FN_MUL, 32'h0);
        send_beat(mau_pkg::OP_NONE, 4'hf, 32'hffffffff, mau_pkg::FN_TRANSP, 32'hffffffff);
        for (int f = 0; f < 8; f++)
            send_beat(mau_pkg::OP_EXEC, 4'hf, 32'hffffffff, mau_pkg::t_fn'(3'(f)),
                      32'h7fffffff);
        send_beat(mau_pkg::OP_EXEC, 4'h0, 32'h0, mau_pkg::FN_DIV_S, 32'h0);
        send_beat(mau_pkg::OP_EXEC, 4'h0, 32'h0, mau_pkg::FN_DIV_S, 32'hffffffff);
        send_beat(mau_pkg::OP_EXEC, 4'h0, 32'h0, mau_pkg::FN_MUL_S, 32'h80000000);
        send_beat(mau_pkg::OP_EXEC, 4'h0, 32'h0, mau_pkg::FN_ADD_S, 32'h80000000);
        send_beat(mau_pkg::OP_EXEC, 4'h0, 32'h0, mau_pkg::FN_SUB_S, 32'h80000000);
        in_valid <= 1'b0;

        // hold off until every expected beat is out
        wait (pending == 0);
        @(negedge clk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < 6; n++) begin
                if ($urandom_range(3) == 0)
                    load_pair();
                else
                    send_beat(mau_pkg::t_op'(2'($urandom_range(1))), 4'($urandom()),
                              pick_value(), mau_pkg::t_fn'(3'($urandom())), $urandom());
                if ($urandom_range(4) == 0)
                    send_beat(mau_pkg::OP_NONE, 4'($urandom()), $urandom(),
                              mau_pkg::t_fn'(3'($urandom())), $urandom());
                send_beat(mau_pkg::OP_EXEC, 4'($urandom()), $urandom(),
                          mau_pkg::t_fn'(3'($urandom_range(7))), pick_scalar());
            end
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/mau_pkg.sv
src/mau_ram.sv
src/mau_div.sv
src/matrix4_arithmetic_unit_core.sv
verif/mau_checker.sv
verif/tb_top.sv
